@@ rtl/ille_pkg.sv @@
// ----------------------------------------------------------------------------
// ille_pkg
// Types and constants of the indexed linked list engine.
// ----------------------------------------------------------------------------
package ille_pkg;

   localparam int CAPACITY = 256;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      K_ADD_FRONT = 3'd0,
      K_ADD_BACK  = 3'd1,
      K_INSERT    = 3'd2,
      K_DEL_FRONT = 3'd3,
      K_DEL_BACK  = 3'd4,
      K_DEL_AT    = 3'd5,
      K_READ      = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_FRONT_INS,
      OP_BACK_INS,
      OP_MID_INS,
      OP_FRONT_DEL,
      OP_BACK_DEL,
      OP_MID_DEL,
      OP_READ
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK,
      S_TAKE,
      S_POP,
      S_VALUE,
      S_BDEL,
      S_FOLLOW,
      S_FOLLOW2,
      S_LINK2,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [8:0]         count;
   } rsp_type;

endpackage

@@ rtl/indexed_linked_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// indexed_linked_list_engine_top
// A rejected request goes straight to completion; front inserts and deletes
// take or pop a slot, a back insert into a non-empty list also links the old
// tail, and indexed requests and delete back first walk the list, reading one
// link per cycle. One transaction at a time: the next is taken in the cycle
// after the result is registered, which waits while an older result stalls.
// Reset is synchronous and empties the list; no clearing pass.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine_top
   import ille_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in, dec_op;
   status_type status_ff, status_in, dec_status;
   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, remain_ff, remain_in, dec_walk;
   logic [CNT_W-1:0]  count_ff, count_in, free_top_ff, free_top_in;
   logic [CNT_W-1:0]  min_top_ff, min_top_in;
   logic signed [31:0] value_ff, value_in, rd_ff, rd_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [31:0]       val_mem [CAPACITY];
   logic [SLOT_W-1:0] link_mem [CAPACITY];
   logic [SLOT_W-1:0] free_mem [CAPACITY];
   logic [31:0]       val_rd_ff;
   logic [SLOT_W-1:0] link_rd_ff, free_rd_ff;

   logic              val_we, link_we, free_we;
   logic [SLOT_W-1:0] val_wa, link_wa, rd_addr, take_idx, take_slot;
   logic [SLOT_W-1:0] link_wd, free_wd;
   logic [31:0]       val_wd;
   logic              accept, full, empty, out_free;
   logic [CNT_W-1:0]  pos;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign full      = (free_top_ff == '0);
   assign empty     = (count_ff == '0);
   assign pos       = CNT_W'(req_data.position);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take_idx  = SLOT_W'(free_top_ff - 1'b1);
   assign take_slot = (CNT_W'(take_idx) < min_top_ff) ? take_idx : free_rd_ff;
   assign rd_addr   = (state_ff == S_IDLE) ? head_ff : link_rd_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic state_type post_walk(op_type op);
      state_type s;
      case (op)
         OP_READ:     s = S_VALUE;
         OP_BACK_DEL: s = S_BDEL;
         default:     s = S_FOLLOW;
      endcase
      return s;
   endfunction

   always_comb begin
      dec_op     = OP_NONE;
      dec_status = ST_OK;
      dec_walk   = '0;
      case (req_data.kind)
         K_ADD_FRONT: begin
            if (full) dec_status = ST_FULL;
            else dec_op = OP_FRONT_INS;
         end
         K_ADD_BACK: begin
            if (full) dec_status = ST_FULL;
            else dec_op = OP_BACK_INS;
         end
         K_INSERT: begin
            if (pos > count_ff) dec_status = ST_RANGE;
            else if (full) dec_status = ST_FULL;
            else if (pos == '0) dec_op = OP_FRONT_INS;
            else if (pos == count_ff) dec_op = OP_BACK_INS;
            else begin
               dec_op   = OP_MID_INS;
               dec_walk = SLOT_W'(pos - 1'b1);
            end
         end
         K_DEL_FRONT: begin
            if (empty) dec_status = ST_EMPTY;
            else dec_op = OP_FRONT_DEL;
         end
         K_DEL_BACK: begin
            if (empty) dec_status = ST_EMPTY;
            else if (count_ff == CNT_W'(1)) dec_op = OP_FRONT_DEL;
            else begin
               dec_op   = OP_BACK_DEL;
               dec_walk = SLOT_W'(count_ff - CNT_W'(2));
            end
         end
         K_DEL_AT: begin
            if (empty) dec_status = ST_EMPTY;
            else if (pos >= count_ff) dec_status = ST_RANGE;
            else if (pos == '0) dec_op = OP_FRONT_DEL;
            else if (pos == count_ff - 1'b1) begin
               dec_op   = OP_BACK_DEL;
               dec_walk = SLOT_W'(count_ff - CNT_W'(2));
            end else begin
               dec_op   = OP_MID_DEL;
               dec_walk = SLOT_W'(pos - 1'b1);
            end
         end
         K_READ: begin
            if (empty) dec_status = ST_EMPTY;
            else if (pos >= count_ff) dec_status = ST_RANGE;
            else begin
               dec_op   = OP_READ;
               dec_walk = req_data.position;
            end
         end
         default: dec_op = OP_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (dec_op)
                  OP_NONE:      state_in = S_DONE;
                  OP_FRONT_INS,
                  OP_BACK_INS:  state_in = S_TAKE;
                  OP_FRONT_DEL: state_in = S_POP;
                  default:      state_in = (dec_walk == '0) ? post_walk(dec_op) : S_WALK;
               endcase
            end
         end
         S_WALK:    if (remain_ff == SLOT_W'(1)) state_in = post_walk(op_ff);
         S_TAKE:    state_in = (op_ff == OP_BACK_INS && !empty) ? S_LINK2 : S_DONE;
         S_FOLLOW:  state_in = (op_ff == OP_MID_INS) ? S_LINK2 : S_FOLLOW2;
         S_POP,
         S_VALUE,
         S_BDEL,
         S_FOLLOW2,
         S_LINK2:   state_in = S_DONE;
         S_DONE:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      remain_in    = remain_ff;
      count_in     = count_ff;
      free_top_in  = free_top_ff;
      min_top_in   = min_top_ff;
      value_in     = value_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      val_we  = 1'b0;
      val_wa  = take_slot;
      val_wd  = value_ff;
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = '0;
      free_we = 1'b0;
      free_wd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = dec_op;
               status_in = dec_status;
               value_in  = req_data.value;
               rd_in     = '0;
               remain_in = dec_walk;
               cur_in    = (dec_op == OP_BACK_INS) ? tail_ff : head_ff;
            end
         end
         S_WALK: begin
            cur_in    = link_rd_ff;
            remain_in = remain_ff - 1'b1;
         end
         S_TAKE: begin
            val_we  = 1'b1;
            link_we = 1'b1;
            link_wa = take_slot;
            link_wd = (op_ff == OP_FRONT_INS) ? head_ff : '0;
            slot_in = take_slot;
            if (op_ff == OP_FRONT_INS) begin
               head_in = take_slot;
               if (empty) tail_in = take_slot;
            end else begin
               if (empty) head_in = take_slot;
               tail_in = take_slot;
            end
            count_in    = count_ff + 1'b1;
            free_top_in = free_top_ff - 1'b1;
            if (free_top_in < min_top_ff) min_top_in = free_top_in;
         end
         S_POP: begin
            free_we     = 1'b1;
            free_wd     = head_ff;
            free_top_in = free_top_ff + 1'b1;
            count_in    = count_ff - 1'b1;
            head_in     = (count_ff == CNT_W'(1)) ? '0 : link_rd_ff;
            if (count_ff == CNT_W'(1)) tail_in = '0;
         end
         S_VALUE: rd_in = val_rd_ff;
         S_BDEL: begin
            link_we     = 1'b1;
            free_we     = 1'b1;
            free_wd     = tail_ff;
            free_top_in = free_top_ff + 1'b1;
            tail_in     = cur_ff;
            count_in    = count_ff - 1'b1;
         end
         S_FOLLOW: begin
            if (op_ff == OP_MID_INS) begin
               val_we      = 1'b1;
               link_we     = 1'b1;
               link_wa     = take_slot;
               link_wd     = link_rd_ff;
               slot_in     = take_slot;
               count_in    = count_ff + 1'b1;
               free_top_in = free_top_ff - 1'b1;
               if (free_top_in < min_top_ff) min_top_in = free_top_in;
            end else begin
               slot_in = link_rd_ff;
            end
         end
         S_FOLLOW2: begin
            link_we     = 1'b1;
            link_wd     = link_rd_ff;
            free_we     = 1'b1;
            free_wd     = slot_ff;
            free_top_in = free_top_ff + 1'b1;
            count_in    = count_ff - 1'b1;
         end
         S_LINK2: begin
            link_we = 1'b1;
            link_wd = slot_ff;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_value = rd_ff;
               rsp_in.status     = status_ff;
               rsp_in.count      = count_ff;
            end
         end
         default: op_in = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         free_top_ff  <= CNT_W'(CAPACITY);
         min_top_ff   <= CNT_W'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         min_top_ff   <= min_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      slot_ff   <= slot_in;
      remain_ff <= remain_in;
      value_ff  <= value_in;
      rd_ff     <= rd_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      val_rd_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (free_we) free_mem[SLOT_W'(free_top_ff)] <= free_wd;
      free_rd_ff <= free_mem[take_idx];
   end

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (count_ff + free_top_ff) == CNT_W'(CAPACITY))
      else $error("count and free stack out of balance");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list keeps head or tail");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted transaction not in progress");

   a_low_mark: assert property (@(posedge clock) disable iff (reset)
      min_top_ff <= free_top_ff)
      else $error("free stack low mark above top");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives list requests with random gaps, stalls the result channel at random,
// and checks every result against a behavioral list kept in the testbench.
// ----------------------------------------------------------------------------
module tb;
   import ille_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class list_scoreboard;
      logic [31:0]       vals[CAPACITY];
      logic [SLOT_W-1:0] links[CAPACITY];
      logic [SLOT_W-1:0] free_stack[CAPACITY];
      int                free_top;
      int                head, tail, size;
      rsp_type           pending[$];
      int                errors;
      int                checked;

      function void clear();
         for (int i = 0; i < CAPACITY; i++) begin
            vals[i] = '0;
            links[i] = '0;
            free_stack[i] = SLOT_W'(i);
         end
         free_top = CAPACITY;
         head = 0;
         tail = 0;
         size = 0;
      endfunction

      function int slot_at(int k);
         int s;
         s = head;
         for (int i = 0; i < k; i++) s = links[s];
         return s;
      endfunction

      function status_type ins_front(logic [31:0] v);
         int s;
         if (free_top == 0) return ST_FULL;
         free_top--;
         s = free_stack[free_top];
         vals[s] = v;
         links[s] = SLOT_W'(head);
         head = s;
         if (size == 0) tail = s;
         size++;
         return ST_OK;
      endfunction

      function status_type ins_back(logic [31:0] v);
         int s;
         if (free_top == 0) return ST_FULL;
         free_top--;
         s = free_stack[free_top];
         vals[s] = v;
         links[s] = '0;
         if (size == 0) head = s;
         else links[tail] = SLOT_W'(s);
         tail = s;
         size++;
         return ST_OK;
      endfunction

      function void release_slot(int s);
         free_stack[free_top] = SLOT_W'(s);
         free_top++;
      endfunction

      function status_type del_front();
         int s;
         if (size == 0) return ST_EMPTY;
         s = head;
         head = links[s];
         release_slot(s);
         size--;
         if (size == 0) begin
            head = 0;
            tail = 0;
         end
         return ST_OK;
      endfunction

      function status_type del_back();
         int p;
         if (size == 0) return ST_EMPTY;
         if (size == 1) begin
            release_slot(head);
            head = 0;
            tail = 0;
         end else begin
            p = slot_at(size - 2);
            release_slot(tail);
            links[p] = '0;
            tail = p;
         end
         size--;
         return ST_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type    e;
         status_type st;
         int         p, prev, t;
         st = ST_OK;
         p = r.position;
         e.read_value = '0;
         case (r.kind)
            K_ADD_FRONT: st = ins_front(r.value);
            K_ADD_BACK: st = ins_back(r.value);
            K_INSERT: begin
               if (p > size) st = ST_RANGE;
               else if (p == 0) st = ins_front(r.value);
               else if (p == size) st = ins_back(r.value);
               else if (free_top == 0) st = ST_FULL;
               else begin
                  prev = slot_at(p - 1);
                  free_top--;
                  t = free_stack[free_top];
                  vals[t] = r.value;
                  links[t] = links[prev];
                  links[prev] = SLOT_W'(t);
                  size++;
               end
            end
            K_DEL_FRONT: st = del_front();
            K_DEL_BACK: st = del_back();
            K_DEL_AT: begin
               if (size == 0) st = ST_EMPTY;
               else if (p >= size) st = ST_RANGE;
               else if (p == 0) st = del_front();
               else if (p == size - 1) st = del_back();
               else begin
                  prev = slot_at(p - 1);
                  t = links[prev];
                  links[prev] = links[t];
                  release_slot(t);
                  size--;
               end
            end
            K_READ: begin
               if (size == 0) st = ST_EMPTY;
               else if (p >= size) st = ST_RANGE;
               else e.read_value = vals[slot_at(p)];
            end
            default: ;
         endcase
         e.status = st;
         e.count = 9'(size);
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", a);
            return;
         end
         e = pending.pop_front();
         if (a.read_value !== e.read_value || a.status !== e.status
             || a.count !== e.count) begin
            errors++;
            if (errors <= 10)
               $display("result %0d: expected value %h status %0d count %0d, got %h %0d %0d",
                        checked, e.read_value, e.status, e.count,
                        a.read_value, a.status, a.count);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   list_scoreboard board = new();
   int  cycles = 0;
   bit  hold_off = 0;
   int  n_sent = 0;
   int  kind_hits[8];
   int  full_hits = 0;

   always #2 clock = ~clock;

   indexed_linked_list_engine_top dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("indexed_linked_list_engine_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);

   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_off) rsp_stall <= 1;
      else if (rsp_valid && !rsp_stall) rsp_stall <= ($urandom_range(0, 3) == 0);
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 10) > 4);
   end

   task automatic send(req_type r);
      int gap;
      gap = $urandom_range(0, 10);
      if (n_sent % 200 > 150) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      kind_hits[r.kind]++;
      if (r.kind <= K_INSERT && board.free_top == 0) full_hits++;
      n_sent++;
   endtask

   function automatic req_type make_req(kind_type k, int p);
      req_type r;
      r.kind = k;
      r.value = $urandom();
      r.position = 8'(p);
      return r;
   endfunction

   function automatic int pick_pos(int sz);
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) return $urandom_range(0, 255);
      if (c == 1) return sz;
      return (sz == 0) ? 0 : $urandom_range(0, sz - 1);
   endfunction

   initial begin
      req_type r;
      int      k, bias;
      board.clear();
      board.errors = 0;
      board.checked = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty list cases, extremes, bad kind
      send(make_req(K_DEL_FRONT, 0));
      send(make_req(K_DEL_BACK, 0));
      send(make_req(K_DEL_AT, 0));
      send(make_req(K_READ, 0));
      send(make_req(K_INSERT, 1));
      r = make_req(K_ADD_FRONT, 0); r.value = 32'h8000_0000; send(r);
      r = make_req(K_ADD_BACK, 255); r.value = 32'h7fff_ffff; send(r);
      r = make_req(K_INSERT, 1); r.value = 32'hffff_ffff; send(r);
      r = make_req(K_INSERT, 3); r.value = 0; send(r);
      send(make_req(K_INSERT, 0));
      send(make_req(K_READ, 0));
      send(make_req(K_READ, 4));
      send(make_req(K_READ, 5));
      send(make_req(K_READ, 255));
      send(make_req(K_DEL_AT, 5));
      send(make_req(K_DEL_AT, 2));
      send(make_req(K_DEL_AT, 3));
      send(make_req(K_DEL_AT, 0));
      r = make_req(K_READ, 255); r.kind = 3'd7; send(r);
      send(make_req(K_DEL_BACK, 0));
      send(make_req(K_DEL_FRONT, 0));
      send(make_req(K_DEL_BACK, 0));

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 12; i++) send(make_req(K_ADD_BACK, 0));
      join

      // fill the pool completely, then overflow, then drain
      while (board.size < CAPACITY) begin
         k = $urandom_range(0, 2);
         send(make_req(kind_type'(k), pick_pos(board.size)));
      end
      send(make_req(K_ADD_FRONT, 0));
      send(make_req(K_ADD_BACK, 0));
      send(make_req(K_INSERT, 100));
      send(make_req(K_INSERT, 255));
      send(make_req(K_READ, 255));
      send(make_req(K_DEL_AT, 255));
      send(make_req(K_DEL_BACK, 0));
      while (board.size > 0) begin
         k = 3 + $urandom_range(0, 3);
         send(make_req(kind_type'(k), pick_pos(board.size)));
      end

      // random phases alternating between growth and shrinkage
      for (int i = 0; i < 750; i++) begin
         bias = ((i / 150) % 2 == 0) ? 7 : 3;
         if ($urandom_range(0, 40) == 0) k = 7;
         else if ($urandom_range(0, 9) < bias) k = $urandom_range(0, 2);
         else k = $urandom_range(3, 6);
         r = make_req(kind_type'(k), pick_pos(board.size));
         if ($urandom_range(0, 20) == 0) r.value = {1'($urandom_range(0, 1)), 31'h0};
         send(r);
      end
      req_valid <= 0;

      while (board.pending.size() > 0) @(posedge clock);
      repeat (CAPACITY + 20) @(posedge clock);
      $display("sent %0d requests, %0d results checked, pool full seen %0d times",
               n_sent, board.checked, full_hits);
      $display("per kind: %0d %0d %0d %0d %0d %0d %0d %0d", kind_hits[0], kind_hits[1],
               kind_hits[2], kind_hits[3], kind_hits[4], kind_hits[5], kind_hits[6],
               kind_hits[7]);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("indexed_linked_list_engine_top: match");
      else
         $display("indexed_linked_list_engine_top: mismatch");
      $finish;
   end
endmodule
